// File: hdl/alkef_pkg.sv
`default_nettype none

package alkef_pkg;

    // sample and configuration widths
    localparam int SAMPLE_W = 12;
    localparam int TOL_W    = 12;
    localparam int TICKS_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int KEY_W    = 4;

    // hold counter width and the width used to compare it with thresholds
    localparam int HOLD_W = 16;
    localparam int CMP_W  = (HOLD_W > TICKS_W) ? HOLD_W : TICKS_W;

    // ladder table: idle first, then keys 1 to 10, in match priority order
    localparam int NUM_WIN = 11;
    localparam int WIN_W   = SAMPLE_W + 2;
    localparam logic [SAMPLE_W-1:0] LADDER [NUM_WIN] = '{
        12'd4095, 12'd3700, 12'd2440, 12'd950, 12'd0, 12'd3385,
        12'd1560, 12'd3120, 12'd1950, 12'd2860, 12'd1100
    };

    // packet constants
    localparam logic [BYTE_W-1:0] PKT_LEN_BYTE = 8'h03;
    localparam logic [BYTE_W-1:0] PKT_CMD_KEY  = 8'h01;
    localparam int PKT_BYTES = 6;
    localparam int POS_W     = 3;

    // event kinds
    localparam logic [1:0] EV_TAP     = 2'd0;
    localparam logic [1:0] EV_PUSH    = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    // packet byte positions
    localparam logic [POS_W-1:0] POS_HDR0 = 3'd0;
    localparam logic [POS_W-1:0] POS_HDR1 = 3'd1;
    localparam logic [POS_W-1:0] POS_LEN  = 3'd2;
    localparam logic [POS_W-1:0] POS_CMD  = 3'd3;
    localparam logic [POS_W-1:0] POS_CODE = 3'd4;
    localparam logic [POS_W-1:0] POS_SUM  = 3'd5;

    // event queue between classifier and serializer
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 2);

    // configuration register map
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_TOL    = 2'd0;
    localparam logic [1:0] REG_LONG   = 2'd1;
    localparam logic [1:0] REG_SHORT  = 2'd2;
    localparam logic [1:0] REG_HEADER = 2'd3;

    // one queue entry: the events caused by one sample
    typedef struct packed {
        logic              two;
        logic [BYTE_W-1:0] code0;
        logic [BYTE_W-1:0] code1;
    } evt_t;

    // event code for a key and an event kind
    function automatic logic [BYTE_W-1:0] ev_code(input logic [KEY_W-1:0] key,
                                                  input logic [1:0] ev);
        logic [KEY_W-1:0] km1;
        km1 = key - KEY_W'(1);
        return {2'b00, km1, 2'b00} + BYTE_W'(1) + {6'b0, ev};
    endfunction

endpackage

`default_nettype wire

// File: hdl/alkef_front.sv
`default_nettype none

module alkef_front
    import alkef_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic [TOL_W-1:0]    window_tolerance,
    input  wire logic [TICKS_W-1:0]  long_press_ticks,
    input  wire logic [TICKS_W-1:0]  short_press_ticks,
    input  wire logic [Q_CNT_W-1:0]  q_count,
    output logic                     push,
    output evt_t                     push_evt
);

    logic                kvalid_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                match_any;
    logic [KEY_W-1:0]    match_key;

    logic [KEY_W-1:0]    prev_key_reg, prev_key_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic                lr_reg, lr_next;

    logic [HOLD_W-1:0]   hold_inc;
    logic [CMP_W-1:0]    hold_cmp, long_cmp, short_cmp;
    logic                is_long, is_short;

    // room for the item in stage a plus the new one
    assign s_tready = (q_count + {{(Q_CNT_W-1){1'b0}}, kvalid_reg}) < Q_CNT_W'(Q_DEPTH);

    // window match, first window in priority order wins
    always_comb begin
        logic [WIN_W-1:0] s_ext, t_ext, l_ext;
        s_ext     = WIN_W'(sample);
        t_ext     = WIN_W'(window_tolerance);
        match_any = 1'b0;
        match_key = '0;
        for (int i = NUM_WIN - 1; i >= 0; i--) begin
            l_ext = WIN_W'(LADDER[i]);
            if ((s_ext + t_ext >= l_ext) && (s_ext <= l_ext + t_ext)) begin
                match_any = 1'b1;
                match_key = KEY_W'(i);
            end
        end
    end

    // stage a: classified key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kvalid_reg <= 1'b0;
        end else begin
            kvalid_reg <= s_tvalid && s_tready && match_any;
        end
        key_reg <= match_key;
    end

    // saturating hold count and threshold compares
    assign hold_inc  = (hold_reg == '1) ? hold_reg : hold_reg + HOLD_W'(1);
    assign hold_cmp  = CMP_W'(hold_inc);
    assign long_cmp  = CMP_W'(long_press_ticks);
    assign short_cmp = CMP_W'(short_press_ticks);
    assign is_long   = hold_cmp >= long_cmp;
    assign is_short  = hold_cmp <= short_cmp;

    // stage b: key state update and event selection
    always_comb begin
        prev_key_next  = prev_key_reg;
        hold_next      = hold_reg;
        lr_next        = lr_reg;
        push           = 1'b0;
        push_evt.two   = 1'b0;
        push_evt.code0 = ev_code(key_reg, EV_PUSH);
        push_evt.code1 = ev_code(prev_key_reg, EV_TAP);
        if (kvalid_reg) begin
            hold_next = hold_inc;
            if (key_reg == prev_key_reg) begin
                if (key_reg != '0 && is_long && !lr_reg) begin
                    push           = 1'b1;
                    push_evt.code0 = ev_code(key_reg, EV_LONG);
                    lr_next        = 1'b1;
                end
            end else begin
                push          = 1'b1;
                hold_next     = '0;
                prev_key_next = key_reg;
                if (key_reg == '0) begin
                    push_evt.code0 = ev_code(prev_key_reg, EV_RELEASE);
                    lr_next        = 1'b0;
                    if (is_short) begin
                        push_evt.two = 1'b1;
                    end else if (is_long && !lr_reg) begin
                        push_evt.two   = 1'b1;
                        push_evt.code1 = ev_code(prev_key_reg, EV_LONG);
                    end
                end
            end
        end
    end

    // key state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg <= '0;
            hold_reg     <= '0;
            lr_reg       <= 1'b0;
        end else begin
            prev_key_reg <= prev_key_next;
            hold_reg     <= hold_next;
            lr_reg       <= lr_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/alkef_evq.sv
`default_nettype none

module alkef_evq
    import alkef_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire evt_t               push_evt,
    input  wire logic               pop,
    output logic                    q_valid,
    output evt_t                    q_evt,
    output logic [Q_CNT_W-1:0]      q_count
);

    evt_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 do_pop;

    assign q_valid = count_reg != '0;
    assign q_evt   = mem_reg[rd_ptr_reg];
    assign q_count = count_reg;
    assign do_pop  = pop && q_valid;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (!push && do_pop) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

`default_nettype wire

// File: hdl/alkef_back.sv
`default_nettype none

module alkef_back
    import alkef_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire evt_t              q_evt,
    output logic                   pop,
    input  wire logic [BYTE_W-1:0] header_byte,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    logic                cur_valid_reg;
    evt_t                cur_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                ev_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_data_reg;
    logic                out_last_reg;

    logic                adv;
    logic                fire;
    logic                at_end;
    logic                last_ev;
    logic [BYTE_W-1:0]   code;
    logic [BYTE_W-1:0]   byte_val;

    assign adv     = !out_valid_reg || m_tready;
    assign fire    = adv && cur_valid_reg;
    assign last_ev = ev_reg || !cur_reg.two;
    assign at_end  = (pos_reg == POS_SUM) && last_ev;
    assign pop     = !cur_valid_reg || (fire && at_end);
    assign code    = ev_reg ? cur_reg.code1 : cur_reg.code0;

    // packet byte for the current position
    always_comb begin
        unique case (pos_reg)
            POS_HDR0, POS_HDR1: byte_val = header_byte;
            POS_LEN:            byte_val = PKT_LEN_BYTE;
            POS_CMD:            byte_val = PKT_CMD_KEY;
            POS_CODE:           byte_val = code;
            POS_SUM:            byte_val = {header_byte[BYTE_W-2:0], 1'b0}
                                           + PKT_LEN_BYTE + PKT_CMD_KEY + code;
            default:            byte_val = '0;
        endcase
    end

    // current entry and position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= POS_HDR0;
            ev_reg        <= 1'b0;
        end else begin
            if (pop) begin
                cur_valid_reg <= q_valid;
                pos_reg       <= POS_HDR0;
                ev_reg        <= 1'b0;
            end else if (fire) begin
                if (pos_reg == POS_SUM) begin
                    pos_reg <= POS_HDR0;
                    ev_reg  <= 1'b1;
                end else begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
        if (pop) begin
            cur_reg <= q_evt;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= cur_valid_reg;
        end
        if (fire) begin
            out_data_reg <= byte_val;
            out_last_reg <= at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/adc_ladder_keypad_event_framer_top.sv
// keypad ladder decoder with event packet framing
//
// input beats (s_ group) carry one 12-bit adc sample of the keypad ladder,
// one per tick. each sample is matched against the idle and ten key windows;
// key changes and long holds become events, and each event goes out on the
// m_ group as a six-byte packet, one byte per beat: header, header, 3, 1,
// event code, byte-sum checksum. m_tlast marks the last byte of a sample.
// a sample that matches no window, or that changes nothing, sends nothing.
//
// throughput: one output byte per cycle while m_tready is high; a sample
// causes 0, 6 or 12 bytes, so samples are taken every cycle while the queue
// has room, and the byte serializer (one byte a cycle) sets the sustained
// sample rate. a four-entry event queue between classifier and serializer
// lets samples still come in while the receiver stalls; s_tready drops
// once the queue, counted with the sample held in the classifier, is full,
// and the output holds its beat until taken.
// reset (aresetn low, synchronous) returns the key state to idle, empties
// the queue and loads the registers with their default values.
// registers over apb: 0x0 window tolerance, 0x4 long-press ticks,
// 0x8 short-press ticks, 0xc header byte.
`default_nettype none

module adc_ladder_keypad_event_framer_top
    import alkef_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // apb register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // sample input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [11:0] sample
    // packet byte output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] tx_byte
    output logic                       m_tlast    // last byte of a sample
);

    logic [TOL_W-1:0]   tol_reg;
    logic [TICKS_W-1:0] long_reg;
    logic [TICKS_W-1:0] short_reg;
    logic [BYTE_W-1:0]  header_reg;
    logic               wr_en;

    logic               push;
    evt_t               push_evt;
    logic               pop;
    logic               q_valid;
    evt_t               q_evt;
    logic [Q_CNT_W-1:0] q_count;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg    <= TOL_W'(125);
            long_reg   <= TICKS_W'(300);
            short_reg  <= TICKS_W'(50);
            header_reg <= BYTE_W'(8'h55);
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_TOL:    tol_reg    <= pwdata[TOL_W-1:0];
                REG_LONG:   long_reg   <= pwdata[TICKS_W-1:0];
                REG_SHORT:  short_reg  <= pwdata[TICKS_W-1:0];
                REG_HEADER: header_reg <= pwdata[BYTE_W-1:0];
                default:    ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (paddr[3:2])
            REG_TOL:    prdata = 32'(tol_reg);
            REG_LONG:   prdata = 32'(long_reg);
            REG_SHORT:  prdata = 32'(short_reg);
            REG_HEADER: prdata = 32'(header_reg);
            default:    prdata = '0;
        endcase
    end

    alkef_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .sample            (s_tdata[SAMPLE_W-1:0]),
        .window_tolerance  (tol_reg),
        .long_press_ticks  (long_reg),
        .short_press_ticks (short_reg),
        .q_count           (q_count),
        .push              (push),
        .push_evt          (push_evt)
    );

    alkef_evq u_evq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_evt (push_evt),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_evt    (q_evt),
        .q_count  (q_count)
    );

    alkef_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_evt       (q_evt),
        .pop         (pop),
        .header_byte (header_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // queue never overfills
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("event queue count beyond depth");

    // an event entry is only pushed while there is room
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_count < Q_CNT_W'(Q_DEPTH)))
        else $error("event pushed into a full queue");

    // no output beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // an accepted sample always finds room in the queue
    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (q_count < Q_CNT_W'(Q_DEPTH)))
        else $error("sample accepted without queue room");

endmodule

`default_nettype wire
